@@ design/refcounted_symbol_table_macros.svh @@
// Assertion macros used by the symbol table checker.
`ifndef REFCOUNTED_SYMBOL_TABLE_MACROS_SVH
`define REFCOUNTED_SYMBOL_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RCST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("symbol table check failed");

// Next-cycle implication, disabled during reset.
`define RCST_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("symbol table check failed");

// Condition checked at every edge, reset included.
`define RCST_ASSERT_ALW(label, cond) \
  label: assert property (@(posedge clk) (cond)) \
    else $error("symbol table check failed");

`endif

@@ design/rcst_pkg.sv @@
// Package with the types, codes and helper functions of the symbol table.
`timescale 1ns / 1ps
`default_nettype none
package rcst_pkg;

  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_RETRIEVE = 2'd1;
  localparam logic [1:0] CMD_REMOVE   = 2'd2;
  localparam logic [1:0] CMD_NONE     = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_BYTE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic [7:0] QMARK      = 8'h3f;
  localparam logic [7:0] ASCII_LO   = 8'd32;
  localparam logic [7:0] ASCII_END  = 8'd127;
  localparam logic [7:0] REF_OFFSET = 8'd95;
  localparam logic [15:0] CNT_MAX   = 16'hffff;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] seq_bytes;
    logic [7:0]  ref_in;
  } req_t;

  typedef struct packed {
    logic [7:0]  ref_out;
    logic [31:0] bytes_out;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [1:0] {
    KIND_IMM,
    KIND_ADD,
    KIND_RETRIEVE,
    KIND_REMOVE
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  slot;
    logic [31:0] seq;
    rsp_t        rsp;
  } item_t;

  typedef struct packed {
    logic [31:0] bytes;
    logic [15:0] cnt;
  } ent_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EXEC,
    BK_SCAN,
    BK_SCAN_END,
    BK_COMMIT,
    BK_LOOKUP
  } bk_state_t;

  // Every byte after the first zero byte is cleared.
  function automatic logic [31:0] normalize(input logic [31:0] b);
    logic [31:0] o;
    logic        live;
    o    = '0;
    live = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (b[8*i +: 8] == 8'd0) live = 1'b0;
      if (live) o[8*i +: 8] = b[8*i +: 8];
    end
    return o;
  endfunction

  function automatic logic [7:0] slot_to_ref(input logic [7:0] s);
    return (s < ASCII_LO) ? s : s + REF_OFFSET;
  endfunction

endpackage
`default_nettype wire

@@ design/rcst_front.sv @@
// Front end: accepts requests, handles the bypass and error cases, queues table work.
`timescale 1ns / 1ps
`default_nettype none
module rcst_front #(
  parameter int NUM_SLOTS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  rcst_pkg::req_t       req,
  output logic                 push,
  output rcst_pkg::item_t      item,
  input  logic                 full
);

  logic            fv;
  logic            accept;
  rcst_pkg::item_t cls;
  logic [8:0]      ref_slot;
  logic            ref_byp;
  logic            ref_ok;

  assign busy   = fv & full;
  assign push   = fv & ~full;
  assign accept = start & ~busy;

  always_comb begin
    ref_byp  = (req.ref_in >= rcst_pkg::ASCII_LO) && (req.ref_in < rcst_pkg::ASCII_END);
    ref_slot = (req.ref_in < rcst_pkg::ASCII_LO) ? {1'b0, req.ref_in}
                                                  : {1'b0, req.ref_in} - {1'b0, rcst_pkg::REF_OFFSET};
    ref_ok   = !ref_byp && (ref_slot < 9'(NUM_SLOTS));
    cls      = '0;
    cls.kind = rcst_pkg::KIND_IMM;
    cls.slot = ref_slot[7:0];
    cls.seq  = rcst_pkg::normalize(req.seq_bytes);
    unique case (req.cmd)
      rcst_pkg::CMD_ADD: begin
        if (req.seq_bytes[7:0] < rcst_pkg::ASCII_LO) begin
          cls.rsp.ref_out = rcst_pkg::QMARK;
          cls.rsp.status  = rcst_pkg::ST_BAD_BYTE;
        end else if (req.seq_bytes[7:0] < rcst_pkg::ASCII_END) begin
          cls.rsp.ref_out = req.seq_bytes[7:0];
        end else begin
          cls.kind = rcst_pkg::KIND_ADD;
        end
      end
      rcst_pkg::CMD_RETRIEVE: begin
        if (ref_byp) begin
          cls.rsp.bytes_out = {24'd0, req.ref_in};
        end else if (!ref_ok) begin
          cls.rsp.bytes_out = {24'd0, rcst_pkg::QMARK};
          cls.rsp.status    = rcst_pkg::ST_EMPTY;
        end else begin
          cls.kind = rcst_pkg::KIND_RETRIEVE;
        end
      end
      rcst_pkg::CMD_REMOVE: begin
        if (!ref_byp) begin
          if (!ref_ok) cls.rsp.status = rcst_pkg::ST_EMPTY;
          else cls.kind = rcst_pkg::KIND_REMOVE;
        end
      end
      default: begin
        cls.kind = rcst_pkg::KIND_IMM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (accept) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item <= cls;
  end

endmodule
`default_nettype wire

@@ design/rcst_fifo.sv @@
// Two-entry queue between the front end and the table engine.
`timescale 1ns / 1ps
`default_nettype none
module rcst_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rcst_pkg::item_t item,
  output logic            full,
  input  logic            pop,
  output rcst_pkg::item_t head,
  output logic            empty
);

  rcst_pkg::item_t ent [2];
  logic [1:0]      cnt;
  logic            wp;
  logic            rp;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign head  = ent[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent[wp] <= item;
  end

endmodule
`default_nettype wire

@@ design/rcst_back.sv @@
// Table engine: slot memory, match and free-slot scan, count updates and results.
`timescale 1ns / 1ps
`default_nettype none
module rcst_back #(
  parameter int NUM_SLOTS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  rcst_pkg::item_t head,
  output logic            pop,
  output logic            done,
  output rcst_pkg::rsp_t  rsp
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(NUM_SLOTS - 1);

  rcst_pkg::bk_state_t state, state_next;
  rcst_pkg::item_t     cur;
  rcst_pkg::ent_t      mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld;
  rcst_pkg::ent_t      rd_data;
  logic                rd_vld;
  logic [31:0]         eff_bytes;
  logic [15:0]         eff_cnt;

  logic [IW-1:0] scan_cnt, chk_idx, m_idx, f_idx, slot_ix;
  logic          chk, found_m, found_f;
  logic [15:0]   m_cnt;

  logic           rd_en, wr_en, emit, scan_start, scan_step;
  logic [IW-1:0]  rd_addr, wr_addr;
  rcst_pkg::ent_t wr_data;
  rcst_pkg::rsp_t emit_rsp;

  assign slot_ix   = cur.slot[IW-1:0];
  assign eff_bytes = rd_vld ? rd_data.bytes : 32'd0;
  assign eff_cnt   = rd_vld ? rd_data.cnt : 16'd0;

  always_comb begin
    state_next = state;
    unique case (state)
      rcst_pkg::BK_IDLE: if (!empty) state_next = rcst_pkg::BK_EXEC;
      rcst_pkg::BK_EXEC: begin
        unique case (cur.kind)
          rcst_pkg::KIND_IMM: state_next = rcst_pkg::BK_IDLE;
          rcst_pkg::KIND_ADD: state_next = rcst_pkg::BK_SCAN;
          default:            state_next = rcst_pkg::BK_LOOKUP;
        endcase
      end
      rcst_pkg::BK_SCAN:     if (scan_cnt == LAST) state_next = rcst_pkg::BK_SCAN_END;
      rcst_pkg::BK_SCAN_END: state_next = rcst_pkg::BK_COMMIT;
      rcst_pkg::BK_COMMIT:   state_next = rcst_pkg::BK_IDLE;
      rcst_pkg::BK_LOOKUP:   state_next = rcst_pkg::BK_IDLE;
      default:               state_next = rcst_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = scan_cnt;
    wr_en      = 1'b0;
    wr_addr    = m_idx;
    wr_data    = '0;
    emit       = 1'b0;
    emit_rsp   = '0;
    scan_start = 1'b0;
    scan_step  = 1'b0;
    unique case (state)
      rcst_pkg::BK_IDLE: pop = !empty;
      rcst_pkg::BK_EXEC: begin
        unique case (cur.kind)
          rcst_pkg::KIND_IMM: begin
            emit     = 1'b1;
            emit_rsp = cur.rsp;
          end
          rcst_pkg::KIND_ADD: scan_start = 1'b1;
          default: begin
            rd_en   = 1'b1;
            rd_addr = slot_ix;
          end
        endcase
      end
      rcst_pkg::BK_SCAN: begin
        rd_en     = 1'b1;
        scan_step = 1'b1;
      end
      rcst_pkg::BK_SCAN_END: rd_en = 1'b0;
      rcst_pkg::BK_COMMIT: begin
        emit = 1'b1;
        if (found_m) begin
          wr_en            = 1'b1;
          wr_addr          = m_idx;
          wr_data.bytes    = cur.seq;
          wr_data.cnt      = (m_cnt == rcst_pkg::CNT_MAX) ? m_cnt : m_cnt + 16'd1;
          emit_rsp.ref_out = rcst_pkg::slot_to_ref(8'(m_idx));
        end else if (found_f) begin
          wr_en            = 1'b1;
          wr_addr          = f_idx;
          wr_data.bytes    = cur.seq;
          wr_data.cnt      = 16'd1;
          emit_rsp.ref_out = rcst_pkg::slot_to_ref(8'(f_idx));
        end else begin
          emit_rsp.ref_out = rcst_pkg::QMARK;
          emit_rsp.status  = rcst_pkg::ST_FULL;
        end
      end
      rcst_pkg::BK_LOOKUP: begin
        emit = 1'b1;
        if (eff_cnt == 16'd0) begin
          emit_rsp.status = rcst_pkg::ST_EMPTY;
          if (cur.kind == rcst_pkg::KIND_RETRIEVE) begin
            emit_rsp.bytes_out = {24'd0, rcst_pkg::QMARK};
          end
        end else if (cur.kind == rcst_pkg::KIND_RETRIEVE) begin
          emit_rsp.bytes_out = eff_bytes;
        end else begin
          wr_en         = 1'b1;
          wr_addr       = slot_ix;
          wr_data.bytes = eff_bytes;
          wr_data.cnt   = eff_cnt - 16'd1;
        end
      end
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rcst_pkg::BK_IDLE;
      vld     <= '0;
      done    <= 1'b0;
      chk     <= 1'b0;
      found_m <= 1'b0;
      found_f <= 1'b0;
    end else begin
      state <= state_next;
      done  <= emit;
      chk   <= scan_step;
      if (wr_en) vld[wr_addr] <= 1'b1;
      if (scan_start) begin
        found_m <= 1'b0;
        found_f <= 1'b0;
      end else if (chk) begin
        if (!found_m && eff_bytes == cur.seq) found_m <= 1'b1;
        if (!found_f && eff_cnt == 16'd0) found_f <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (emit) rsp <= emit_rsp;
    chk_idx <= scan_cnt;
    if (scan_start) scan_cnt <= '0;
    else if (scan_step) scan_cnt <= scan_cnt + 1'b1;
    if (chk && !found_m && eff_bytes == cur.seq) begin
      m_idx <= chk_idx;
      m_cnt <= eff_cnt;
    end
    if (chk && !found_f && eff_cnt == 16'd0) f_idx <= chk_idx;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_vld  <= vld[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ design/refcounted_symbol_table.sv @@
// Top level of the reference-counted symbol table.
// The table engine holds one request at a time; an add makes a single scan over the slot memory.
// Synchronous reset empties the queue and marks every slot unwritten, so the table reads as zero.
`timescale 1ns / 1ps
`default_nettype none
module refcounted_symbol_table #(
  parameter int NUM_SLOTS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  rcst_pkg::req_t req,
  output logic           done,
  output rcst_pkg::rsp_t rsp
);

  logic            push, full, pop, empty;
  rcst_pkg::item_t item, head;

  rcst_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .push  (push),
    .item  (item),
    .full  (full)
  );

  rcst_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .item  (item),
    .full  (full),
    .pop   (pop),
    .head  (head),
    .empty (empty)
  );

  rcst_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (empty),
    .head  (head),
    .pop   (pop),
    .done  (done),
    .rsp   (rsp)
  );

endmodule
`default_nettype wire

@@ design/rcst_checker.sv @@
// Port-level checker for the symbol table and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "refcounted_symbol_table_macros.svh"
module rcst_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input rcst_pkg::rsp_t rsp
);

  `RCST_ASSERT_ALW(a_quiet_after_reset, rst || !$past(rst) || (!done && !busy))
  `RCST_ASSERT_NXT(a_done_single, done, !done)
  `RCST_ASSERT_IMP(a_bad_byte_rsp, done && rsp.status == rcst_pkg::ST_BAD_BYTE, rsp.ref_out == rcst_pkg::QMARK && rsp.bytes_out == 32'd0)
  `RCST_ASSERT_IMP(a_full_rsp, done && rsp.status == rcst_pkg::ST_FULL, rsp.ref_out == rcst_pkg::QMARK && rsp.bytes_out == 32'd0)
  `RCST_ASSERT_IMP(a_empty_rsp, done && start && rsp.status == rcst_pkg::ST_EMPTY, rsp.ref_out == 8'd0)

endmodule

bind refcounted_symbol_table rcst_checker u_rcst_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
`default_nettype wire

@@ tb/refcounted_symbol_table_test.sv @@
// Self-checking testbench for the reference-counted symbol table.
`timescale 1ns / 1ps
module refcounted_symbol_table_test;

  localparam int SLOTS       = 64;
  localparam int POOL        = 96;
  localparam int QUIET_LIMIT = 4000;

  logic clk;
  logic rst = 1'b1;

  logic           start_main = 1'b0;
  rcst_pkg::req_t req_main   = '0;
  logic           busy_main;
  logic           done_main;
  rcst_pkg::rsp_t rsp_main;

  logic [31:0] seq_store [SLOTS];
  logic [15:0] use_store [SLOTS];
  logic [31:0] seq_pool [POOL];

  rcst_pkg::rsp_t main_rsp_due[$];

  int sender_gap_pct = 28;
  int error_count    = 0;
  int quiet_cycles   = 0;

  refcounted_symbol_table #(.NUM_SLOTS(SLOTS)) u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start_main),
    .busy (busy_main),
    .req  (req_main),
    .done (done_main),
    .rsp  (rsp_main)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rcst_pkg::req_t make_req(input logic [1:0] c, input logic [31:0] b,
                                              input logic [7:0] rf);
    rcst_pkg::req_t r;
    r.cmd       = c;
    r.seq_bytes = b;
    r.ref_in    = rf;
    return r;
  endfunction

  function automatic logic [7:0] slot_ref(input int s);
    int r;
    r = (s < int'(rcst_pkg::ASCII_LO)) ? s : s + int'(rcst_pkg::REF_OFFSET);
    return r[7:0];
  endfunction

  // Applies one request to the table copy and returns the response it must give.
  function automatic rcst_pkg::rsp_t apply_to_table(input rcst_pkg::req_t r);
    rcst_pkg::rsp_t o;
    int             hit;
    int             s;
    logic [7:0]     first;
    logic [31:0]    norm;
    o     = '0;
    first = r.seq_bytes[7:0];
    case (r.cmd)
      rcst_pkg::CMD_ADD: begin
        if (first < rcst_pkg::ASCII_LO) begin
          o.ref_out = rcst_pkg::QMARK;
          o.status  = rcst_pkg::ST_BAD_BYTE;
        end else if (first < rcst_pkg::ASCII_END) begin
          o.ref_out = first;
        end else begin
          norm = r.seq_bytes;
          if (norm[15:8] == 8'd0) norm[31:8] = '0;
          else if (norm[23:16] == 8'd0) norm[31:16] = '0;
          hit = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && seq_store[i] == norm) hit = i;
          end
          if (hit >= 0) begin
            if (use_store[hit] != rcst_pkg::CNT_MAX) use_store[hit] = use_store[hit] + 16'd1;
          end else begin
            for (int i = 0; i < SLOTS; i++) begin
              if (hit < 0 && use_store[i] == 16'd0) hit = i;
            end
            if (hit >= 0) begin
              seq_store[hit] = norm;
              use_store[hit] = 16'd1;
            end
          end
          if (hit >= 0) begin
            o.ref_out = slot_ref(hit);
          end else begin
            o.ref_out = rcst_pkg::QMARK;
            o.status  = rcst_pkg::ST_FULL;
          end
        end
      end
      rcst_pkg::CMD_RETRIEVE, rcst_pkg::CMD_REMOVE: begin
        if (r.ref_in >= rcst_pkg::ASCII_LO && r.ref_in < rcst_pkg::ASCII_END) begin
          if (r.cmd == rcst_pkg::CMD_RETRIEVE) o.bytes_out = {24'd0, r.ref_in};
        end else begin
          s = (r.ref_in < rcst_pkg::ASCII_LO) ? int'(r.ref_in)
                                              : int'(r.ref_in) - int'(rcst_pkg::REF_OFFSET);
          if (s >= SLOTS || use_store[s] == 16'd0) begin
            o.status = rcst_pkg::ST_EMPTY;
            if (r.cmd == rcst_pkg::CMD_RETRIEVE) o.bytes_out = {24'd0, rcst_pkg::QMARK};
          end else if (r.cmd == rcst_pkg::CMD_RETRIEVE) begin
            o.bytes_out = seq_store[s];
          end else begin
            use_store[s] = use_store[s] - 16'd1;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string unit_name, input string what,
                                 input logic [31:0] want, input logic [31:0] got);
    error_count++;
    $display("%0t %s: %s expected %h got %h", $time, unit_name, what, want, got);
  endtask

  task automatic compare_rsp(input string unit_name, input rcst_pkg::rsp_t want,
                             input rcst_pkg::rsp_t got);
    if (got.ref_out !== want.ref_out)
      report_mismatch(unit_name, "ref_out", 32'(want.ref_out), 32'(got.ref_out));
    if (got.bytes_out !== want.bytes_out)
      report_mismatch(unit_name, "bytes_out", want.bytes_out, got.bytes_out);
    if (got.status !== want.status)
      report_mismatch(unit_name, "status", 32'(want.status), 32'(got.status));
  endtask

  always @(posedge clk) begin
    if (!rst && done_main) begin
      if (main_rsp_due.size() == 0) report_mismatch("main", "unrequested result", 32'd0, 32'd0);
      else compare_rsp("main", main_rsp_due.pop_front(), rsp_main);
    end
  end

  always @(posedge clk) begin
    if (rst || (start_main && !busy_main) || done_main) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[refcounted_symbol_table] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Start stays high after acceptance so that back-to-back requests need no second assignment.
  task automatic send_request(input rcst_pkg::req_t r);
    int idle_len;
    if ($urandom_range(99) < sender_gap_pct) begin
      idle_len = ($urandom_range(3) == 0) ? int'($urandom_range(5, 80))
                                          : int'($urandom_range(1, 4));
      start_main <= 1'b0;
      repeat (idle_len) @(posedge clk);
    end
    start_main <= 1'b1;
    req_main   <= r;
    do @(posedge clk); while (busy_main);
    main_rsp_due.push_back(apply_to_table(r));
  endtask

  task automatic settle();
    start_main <= 1'b0;
    while (main_rsp_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_ascii_and_control();
    send_request(make_req(rcst_pkg::CMD_ADD, 32'hffffff00, 8'hff));
    send_request(make_req(rcst_pkg::CMD_ADD, 32'h1234561f, 8'h00));
    send_request(make_req(rcst_pkg::CMD_ADD, 32'hffffff20, 8'h00));
    send_request(make_req(rcst_pkg::CMD_ADD, 32'h0000007e, 8'h00));
    send_request(make_req(rcst_pkg::CMD_RETRIEVE, 32'hffffffff, 8'd32));
    send_request(make_req(rcst_pkg::CMD_RETRIEVE, 32'h00000000, 8'd126));
    send_request(make_req(rcst_pkg::CMD_REMOVE, 32'h00000000, 8'd32));
    send_request(make_req(rcst_pkg::CMD_NONE, 32'hffffffff, 8'hff));
  endtask

  task automatic test_slot_lifecycle();
    send_request(make_req(rcst_pkg::CMD_ADD, 32'hbf9f98f0, 8'h00));
    send_request(make_req(rcst_pkg::CMD_ADD, 32'hcdab00e2, 8'h00));
    send_request(make_req(rcst_pkg::CMD_ADD, 32'h000000e2, 8'h00));
    send_request(make_req(rcst_pkg::CMD_ADD, 32'h0000007f, 8'h00));
    send_request(make_req(rcst_pkg::CMD_ADD, 32'hffffffff, 8'h00));
    send_request(make_req(rcst_pkg::CMD_RETRIEVE, 32'h0, 8'd1));
    send_request(make_req(rcst_pkg::CMD_RETRIEVE, 32'h0, 8'd3));
    send_request(make_req(rcst_pkg::CMD_REMOVE, 32'h0, 8'd2));
    send_request(make_req(rcst_pkg::CMD_RETRIEVE, 32'h0, 8'd2));
    send_request(make_req(rcst_pkg::CMD_REMOVE, 32'h0, 8'd2));
    send_request(make_req(rcst_pkg::CMD_ADD, 32'h0000007f, 8'h00));
    send_request(make_req(rcst_pkg::CMD_REMOVE, 32'h0, 8'd0));
    send_request(make_req(rcst_pkg::CMD_ADD, 32'h0000a1c3, 8'h00));
    send_request(make_req(rcst_pkg::CMD_RETRIEVE, 32'h0, 8'd31));
    send_request(make_req(rcst_pkg::CMD_RETRIEVE, 32'h0, 8'd127));
    send_request(make_req(rcst_pkg::CMD_RETRIEVE, 32'h0, 8'd159));
    send_request(make_req(rcst_pkg::CMD_REMOVE, 32'h0, 8'd255));
  endtask

  function automatic logic [7:0] pick_ref(input bit want_live);
    int s0;
    int s;
    s0 = int'($urandom_range(0, SLOTS - 1));
    if (want_live) begin
      for (int k = 0; k < SLOTS; k++) begin
        s = (s0 + k) % SLOTS;
        if (use_store[s] != 16'd0) return slot_ref(s);
      end
    end
    return slot_ref(s0);
  endfunction

  task automatic run_random_phase(input int n, input int add_pct, input int noise_pct);
    rcst_pkg::req_t r;
    int             pick;
    repeat (n) begin
      pick = int'($urandom_range(99));
      if (pick < noise_pct) begin
        r = make_req(2'($urandom_range(0, 3)), $urandom, 8'($urandom_range(0, 255)));
      end else if ($urandom_range(99) < add_pct) begin
        r = make_req(rcst_pkg::CMD_ADD, seq_pool[$urandom_range(0, POOL - 1)],
                     8'($urandom_range(0, 255)));
      end else begin
        r = make_req($urandom_range(0, 1) ? rcst_pkg::CMD_RETRIEVE : rcst_pkg::CMD_REMOVE,
                     $urandom, pick_ref($urandom_range(99) < 80));
      end
      send_request(r);
    end
  endtask

  task automatic test_random_traffic();
    logic [31:0] v;
    int          k;
    for (int i = 0; i < POOL; i++) begin
      v      = $urandom;
      v[7:0] = 8'($urandom_range(127, 255));
      if ($urandom_range(99) < 30) begin
        k = int'($urandom_range(1, 3));
        v[8*k +: 8] = 8'd0;
      end
      seq_pool[i] = v;
    end
    sender_gap_pct = 28;
    run_random_phase(300, 75, 10);
    sender_gap_pct = 0;
    run_random_phase(200, 50, 10);
    sender_gap_pct = 28;
    run_random_phase(300, 25, 10);
    run_random_phase(150, 50, 40);
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      seq_store[s] = '0;
      use_store[s] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_ascii_and_control();
    test_slot_lifecycle();
    test_random_traffic();
    settle();
    repeat (SLOTS + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("[refcounted_symbol_table] OK");
    end else begin
      $display("[refcounted_symbol_table] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/rcst_pkg.sv
design/rcst_front.sv
design/rcst_fifo.sv
design/rcst_back.sv
design/refcounted_symbol_table.sv
design/rcst_checker.sv
tb/refcounted_symbol_table_test.sv
